/* design/euler_angles_to_rotation_matrix_defines.svh */
// ----------------------------------------------------------------------------
// Euler to rotation matrix: assertion macros
// Concurrent assertion helpers. They expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH

`ifndef SYNTH
`define EATR_ASSERT_IMPL(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("eatr: check failed");
`define EATR_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("eatr: check failed");
`else
`define EATR_ASSERT_IMPL(name, clk, rstn, pre, post)
`define EATR_ASSERT_NEXT(name, clk, rstn, pre, post)
`endif

`endif

/* design/eatr_pkg.sv */
// ----------------------------------------------------------------------------
// Euler to rotation matrix: package
// Types, constants and arithmetic helpers shared by the block.
// ----------------------------------------------------------------------------
package eatr_pkg;

  localparam int ANG_W         = 18;
  localparam int MAT_W         = 16;
  localparam int OUT_FRAC_BITS = 15;
  localparam int CORDIC_STEPS  = 16;
  localparam int CW            = 34;  // CORDIC datapath width, Q2.30 plus guard
  localparam int PW            = 68;  // product width
  localparam int SW            = 69;  // sum width

  localparam logic signed [18:0] ANG_FULL     = 19'sd92160;
  localparam logic signed [18:0] ANG_HALF     = 19'sd46080;
  localparam logic signed [18:0] ANG_QUARTER  = 19'sd23040;
  localparam logic signed [18:0] ANG_3QUARTER = 19'sd69120;

  localparam logic signed [27:0] DEG_TO_RAD_Q32 = 28'sd74961321;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = CW'(652032874);

  localparam logic [6:0] RAD_SHIFT = 7'd10;
  localparam logic [6:0] MID_SHIFT = 7'd30;
  localparam logic [6:0] OUT_SHIFT = 7'(60 - OUT_FRAC_BITS);

  localparam logic signed [MAT_W-1:0] MAT_MAX = 16'sd32767;
  localparam logic signed [MAT_W-1:0] MAT_MIN = -16'sd32767;

  typedef logic signed [ANG_W-1:0] ang_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 cneg;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] m00;
    logic signed [MAT_W-1:0] m01;
    logic signed [MAT_W-1:0] m02;
    logic signed [MAT_W-1:0] m10;
    logic signed [MAT_W-1:0] m11;
    logic signed [MAT_W-1:0] m12;
    logic signed [MAT_W-1:0] m20;
    logic signed [MAT_W-1:0] m21;
    logic signed [MAT_W-1:0] m22;
  } mat_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] k);
    logic signed [CW-1:0] r;
    unique case (k)
      5'd0:  r = CW'(843314857);
      5'd1:  r = CW'(497837829);
      5'd2:  r = CW'(263043837);
      5'd3:  r = CW'(133525159);
      5'd4:  r = CW'(67021687);
      5'd5:  r = CW'(33543516);
      5'd6:  r = CW'(16775851);
      5'd7:  r = CW'(8388437);
      5'd8:  r = CW'(4194283);
      5'd9:  r = CW'(2097149);
      5'd10: r = CW'(1048576);
      5'd11: r = CW'(524288);
      5'd12: r = CW'(262144);
      5'd13: r = CW'(131072);
      5'd14: r = CW'(65536);
      5'd15: r = CW'(32768);
      5'd16: r = CW'(16384);
      5'd17: r = CW'(8192);
      5'd18: r = CW'(4096);
      5'd19: r = CW'(2048);
      5'd20: r = CW'(1024);
      5'd21: r = CW'(512);
      5'd22: r = CW'(256);
      5'd23: r = CW'(128);
      5'd24: r = CW'(64);
      5'd25: r = CW'(32);
      5'd26: r = CW'(16);
      5'd27: r = CW'(8);
      5'd28: r = CW'(4);
      5'd29: r = CW'(2);
      5'd30: r = CW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round half away from zero, then drop s fractional bits.
  function automatic logic signed [SW-1:0] rnd_shift(input logic signed [SW-1:0] v,
                                                      input logic [6:0] s);
    logic [SW-1:0] mag;
    logic [SW-1:0] half;
    mag  = v[SW-1] ? SW'(-v) : SW'(v);
    half = SW'(1) << (s - 7'd1);
    mag  = (mag + half) >> s;
    return v[SW-1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [MAT_W-1:0] to_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    logic signed [MAT_W-1:0] o;
    r = rnd_shift(v, OUT_SHIFT);
    if (r > SW'(MAT_MAX)) begin
      o = MAT_MAX;
    end else if (r < SW'(MAT_MIN)) begin
      o = MAT_MIN;
    end else begin
      o = r[MAT_W-1:0];
    end
    return o;
  endfunction

endpackage

/* design/eatr_if.sv */
// ----------------------------------------------------------------------------
// Euler to rotation matrix: channel interfaces
// Valid/ready channels for the angle words and the matrix words.
// ----------------------------------------------------------------------------
interface eatr_in_if;
  import eatr_pkg::*;

  logic valid;
  logic ready;
  ang_t pitch_deg;
  ang_t roll_deg;
  ang_t yaw_deg;

  modport source (output valid, output pitch_deg, output roll_deg, output yaw_deg,
                  input ready);
  modport sink (input valid, input pitch_deg, input roll_deg, input yaw_deg,
                output ready);
endinterface

interface eatr_out_if;
  import eatr_pkg::*;

  logic valid;
  logic ready;
  logic signed [MAT_W-1:0] m00;
  logic signed [MAT_W-1:0] m01;
  logic signed [MAT_W-1:0] m02;
  logic signed [MAT_W-1:0] m10;
  logic signed [MAT_W-1:0] m11;
  logic signed [MAT_W-1:0] m12;
  logic signed [MAT_W-1:0] m20;
  logic signed [MAT_W-1:0] m21;
  logic signed [MAT_W-1:0] m22;

  modport source (output valid, output m00, output m01, output m02, output m10,
                  output m11, output m12, output m20, output m21, output m22,
                  input ready);
  modport sink (input valid, input m00, input m01, input m02, input m10,
                input m11, input m12, input m20, input m21, input m22,
                output ready);
endinterface

/* design/eatr_prep.sv */
// ----------------------------------------------------------------------------
// Euler to rotation matrix: angle preparation
// Reduces each angle modulo 360 degrees, folds it into +-90 degrees and
// converts it to Q2.30 radians, seeding one CORDIC lane per angle.
// ----------------------------------------------------------------------------
module eatr_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  eatr_pkg::ang_t [2:0] ang_i,
  output logic                valid_o,
  input  logic                ready_i,
  output eatr_pkg::lanes_t    lanes_o
);
  import eatr_pkg::*;

  logic                v0_q, v1_q, v2_q;
  logic                r0, r1, r2;
  logic signed [15:0]  t_d [3];
  logic                cn_d [3];
  logic signed [15:0]  t_q [3];
  logic                cn0_q [3];
  logic signed [43:0]  p_q [3];
  logic                cn1_q [3];
  lanes_t              lanes_q;
  logic signed [18:0]  a [3];

  assign r2      = !v2_q || ready_i;
  assign r1      = !v1_q || r2;
  assign r0      = !v0_q || r1;
  assign ready_o = r0;
  assign valid_o = v2_q;
  assign lanes_o = lanes_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      a[l] = {ang_i[l][ANG_W-1], ang_i[l]};
      if (a[l] < 0) a[l] = a[l] + ANG_FULL;
      if (a[l] < 0) a[l] = a[l] + ANG_FULL;
      if (a[l] >= ANG_FULL) a[l] = a[l] - ANG_FULL;
      cn_d[l] = 1'b0;
      if (a[l] <= ANG_QUARTER) begin
        t_d[l] = a[l][15:0];
      end else if (a[l] < ANG_3QUARTER) begin
        t_d[l]  = 16'(ANG_HALF - a[l]);
        cn_d[l] = 1'b1;
      end else begin
        t_d[l] = 16'(a[l] - ANG_FULL);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (r0) v0_q <= valid_i;
      if (r1) v1_q <= v0_q;
      if (r2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      if (r0) begin
        t_q[l]   <= t_d[l];
        cn0_q[l] <= cn_d[l];
      end
      if (r1) begin
        p_q[l]   <= 44'(t_q[l]) * 44'(DEG_TO_RAD_Q32);
        cn1_q[l] <= cn0_q[l];
      end
      if (r2) begin
        lanes_q[l].x    <= CORDIC_GAIN_Q30;
        lanes_q[l].y    <= '0;
        lanes_q[l].z    <= CW'(rnd_shift(SW'(p_q[l]), RAD_SHIFT));
        lanes_q[l].cneg <= cn1_q[l];
      end
    end
  end

endmodule

/* design/eatr_cell.sv */
// ----------------------------------------------------------------------------
// Euler to rotation matrix: CORDIC cell
// One rotation-mode CORDIC iteration for the three angle lanes, with its
// own pipeline register and handshake.
// ----------------------------------------------------------------------------
module eatr_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [4:0]       step_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  eatr_pkg::lanes_t lanes_i,
  output logic             valid_o,
  input  logic             ready_i,
  output eatr_pkg::lanes_t lanes_o
);
  import eatr_pkg::*;

  logic                 valid_q;
  lanes_t               lanes_d, lanes_q;
  logic signed [CW-1:0] dx, dy, at;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

  always_comb begin
    at = atan_q30(step_i);
    dx = '0;
    dy = '0;
    for (int l = 0; l < 3; l++) begin
      dx = lanes_i[l].y >>> step_i;
      dy = lanes_i[l].x >>> step_i;
      lanes_d[l].cneg = lanes_i[l].cneg;
      // rotate toward zero residual angle
      if (!lanes_i[l].z[CW-1]) begin
        lanes_d[l].x = lanes_i[l].x - dx;
        lanes_d[l].y = lanes_i[l].y + dy;
        lanes_d[l].z = lanes_i[l].z - at;
      end else begin
        lanes_d[l].x = lanes_i[l].x + dx;
        lanes_d[l].y = lanes_i[l].y - dy;
        lanes_d[l].z = lanes_i[l].z + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) lanes_q <= lanes_d;
  end

endmodule

/* design/eatr_mat.sv */
// ----------------------------------------------------------------------------
// Euler to rotation matrix: matrix assembly
// Forms the nine entries from the sines and cosines: sign fix, products,
// middle rounding, triple products, sums, then round and saturate.
// ----------------------------------------------------------------------------
module eatr_mat (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  eatr_pkg::lanes_t lanes_i,
  output logic             valid_o,
  input  logic             ready_i,
  output eatr_pkg::mat_t   mat_o
);
  import eatr_pkg::*;

  localparam int NS = 6;

  logic [NS-1:0] v_q;
  logic [NS-1:0] rdy;

  // stage 0: cos and sin, lane 0 pitch, 1 roll, 2 yaw
  logic signed [CW-1:0] c_q [3];
  logic signed [CW-1:0] s_q [3];
  // stage 1
  logic signed [PW-1:0] spsy_p_q, spcy_p_q, crcy_q, crsy_q, srcy_q, srsy_q;
  logic signed [PW-1:0] srcp_q, cpsy_q, cpcy_q, crcp_q;
  logic signed [CW-1:0] sr1_q, cr1_q, sp1_q;
  // stage 2
  logic signed [CW-1:0] spsy_q, spcy_q, sr2_q, cr2_q, sp2_q;
  logic signed [PW-1:0] crcy2_q, crsy2_q, srcy2_q, srsy2_q, srcp2_q, cpsy2_q;
  logic signed [PW-1:0] cpcy2_q, crcp2_q;
  // stage 3
  logic signed [PW-1:0] srspsy_q, srspcy_q, crspsy_q, crspcy_q;
  logic signed [PW-1:0] crcy3_q, crsy3_q, srcy3_q, srsy3_q, srcp3_q, cpsy3_q;
  logic signed [PW-1:0] cpcy3_q, crcp3_q;
  logic signed [CW-1:0] sp3_q;
  // stage 4
  logic signed [SW-1:0] e_q [9];
  // stage 5
  mat_t                 mat_q;

  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NS-1];
  assign mat_o   = mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int l = 0; l < 3; l++) begin
        c_q[l] <= lanes_i[l].cneg ? -lanes_i[l].x : lanes_i[l].x;
        s_q[l] <= lanes_i[l].y;
      end
    end
    if (rdy[1]) begin
      spsy_p_q <= PW'(s_q[0]) * PW'(s_q[2]);
      spcy_p_q <= PW'(s_q[0]) * PW'(c_q[2]);
      crcy_q   <= PW'(c_q[1]) * PW'(c_q[2]);
      crsy_q   <= PW'(c_q[1]) * PW'(s_q[2]);
      srcy_q   <= PW'(s_q[1]) * PW'(c_q[2]);
      srsy_q   <= PW'(s_q[1]) * PW'(s_q[2]);
      srcp_q   <= PW'(s_q[1]) * PW'(c_q[0]);
      cpsy_q   <= PW'(c_q[0]) * PW'(s_q[2]);
      cpcy_q   <= PW'(c_q[0]) * PW'(c_q[2]);
      crcp_q   <= PW'(c_q[1]) * PW'(c_q[0]);
      sr1_q    <= s_q[1];
      cr1_q    <= c_q[1];
      sp1_q    <= s_q[0];
    end
    if (rdy[2]) begin
      spsy_q  <= CW'(rnd_shift(SW'(spsy_p_q), MID_SHIFT));
      spcy_q  <= CW'(rnd_shift(SW'(spcy_p_q), MID_SHIFT));
      sr2_q   <= sr1_q;
      cr2_q   <= cr1_q;
      sp2_q   <= sp1_q;
      crcy2_q <= crcy_q;
      crsy2_q <= crsy_q;
      srcy2_q <= srcy_q;
      srsy2_q <= srsy_q;
      srcp2_q <= srcp_q;
      cpsy2_q <= cpsy_q;
      cpcy2_q <= cpcy_q;
      crcp2_q <= crcp_q;
    end
    if (rdy[3]) begin
      srspsy_q <= PW'(sr2_q) * PW'(spsy_q);
      srspcy_q <= PW'(sr2_q) * PW'(spcy_q);
      crspsy_q <= PW'(cr2_q) * PW'(spsy_q);
      crspcy_q <= PW'(cr2_q) * PW'(spcy_q);
      crcy3_q  <= crcy2_q;
      crsy3_q  <= crsy2_q;
      srcy3_q  <= srcy2_q;
      srsy3_q  <= srsy2_q;
      srcp3_q  <= srcp2_q;
      cpsy3_q  <= cpsy2_q;
      cpcy3_q  <= cpcy2_q;
      crcp3_q  <= crcp2_q;
      sp3_q    <= sp2_q;
    end
    if (rdy[4]) begin
      e_q[0] <= SW'(crcy3_q) + SW'(srspsy_q);
      e_q[1] <= SW'(srspcy_q) - SW'(crsy3_q);
      e_q[2] <= SW'(srcp3_q);
      e_q[3] <= SW'(cpsy3_q);
      e_q[4] <= SW'(cpcy3_q);
      e_q[5] <= -(SW'(sp3_q) <<< MID_SHIFT);
      e_q[6] <= SW'(crspsy_q) - SW'(srcy3_q);
      e_q[7] <= SW'(srsy3_q) + SW'(crspcy_q);
      e_q[8] <= SW'(crcp3_q);
    end
    if (rdy[5]) begin
      mat_q.m00 <= to_out(e_q[0]);
      mat_q.m01 <= to_out(e_q[1]);
      mat_q.m02 <= to_out(e_q[2]);
      mat_q.m10 <= to_out(e_q[3]);
      mat_q.m11 <= to_out(e_q[4]);
      mat_q.m12 <= to_out(e_q[5]);
      mat_q.m20 <= to_out(e_q[6]);
      mat_q.m21 <= to_out(e_q[7]);
      mat_q.m22 <= to_out(e_q[8]);
    end
  end

endmodule

/* design/euler_angles_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// Euler angles to rotation matrix
// R = Ry(roll) * Rx(pitch) * Rz(yaw) from three Q10.8 degree angles, with a
// chain of CORDIC cells for sine and cosine and a multiplier pipeline.
// ----------------------------------------------------------------------------
//   channel  dir  word                            handshake
//   in_i     in   pitch_deg, roll_deg, yaw_deg    valid / ready
//   out_o    out  m00 .. m22, Q1.15 saturated     valid / ready
//
// One word per cycle sustained while out_o is ready; a word passes the
// preparation registers, the CORDIC cell chain and the matrix stages in order.
// Every stage has its own valid bit and fills bubbles, so input words are
// still taken while a finished word waits at the output, until the pipe is full.
// Reset clears the valid bits only; the datapath needs no reset.
// ----------------------------------------------------------------------------
`include "euler_angles_to_rotation_matrix_defines.svh"

module euler_angles_to_rotation_matrix (
  input  logic       clk_i,
  input  logic       rst_ni,
  eatr_in_if.sink    in_i,
  eatr_out_if.source out_o
);
  import eatr_pkg::*;

  logic            cv  [CORDIC_STEPS+1];
  logic            crd [CORDIC_STEPS+1];
  lanes_t          cw  [CORDIC_STEPS+1];
  ang_t [2:0]      ang;
  mat_t            mat;

  assign ang = {in_i.yaw_deg, in_i.roll_deg, in_i.pitch_deg};

  eatr_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .ang_i   (ang),
    .valid_o (cv[0]),
    .ready_i (crd[0]),
    .lanes_o (cw[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    eatr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (5'(k)),
      .valid_i (cv[k]),
      .ready_o (crd[k]),
      .lanes_i (cw[k]),
      .valid_o (cv[k+1]),
      .ready_i (crd[k+1]),
      .lanes_o (cw[k+1])
    );
  end

  eatr_mat u_mat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv[CORDIC_STEPS]),
    .ready_o (crd[CORDIC_STEPS]),
    .lanes_i (cw[CORDIC_STEPS]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .mat_o   (mat)
  );

  assign out_o.m00 = mat.m00;
  assign out_o.m01 = mat.m01;
  assign out_o.m02 = mat.m02;
  assign out_o.m10 = mat.m10;
  assign out_o.m11 = mat.m11;
  assign out_o.m12 = mat.m12;
  assign out_o.m20 = mat.m20;
  assign out_o.m21 = mat.m21;
  assign out_o.m22 = mat.m22;

  `EATR_ASSERT_IMPL(a_empty_takes, clk_i, rst_ni, !out_o.valid, in_i.ready)
  `EATR_ASSERT_NEXT(a_cell_handoff, clk_i, rst_ni, cv[0] && crd[0], cv[1])
  `EATR_ASSERT_IMPL(a_sat_row0, clk_i, rst_ni, out_o.valid, out_o.m00 >= MAT_MIN && out_o.m01 >= MAT_MIN && out_o.m02 >= MAT_MIN)
  `EATR_ASSERT_IMPL(a_sat_rows12, clk_i, rst_ni, out_o.valid, out_o.m10 >= MAT_MIN && out_o.m11 >= MAT_MIN && out_o.m12 >= MAT_MIN && out_o.m20 >= MAT_MIN && out_o.m21 >= MAT_MIN && out_o.m22 >= MAT_MIN)

endmodule

/* tb/eatr_tb_if.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Euler to rotation matrix test: channel wrappers
// The block's own channel interfaces are used; this file keeps the
// testbench file order (package, interfaces, top) and adds only angles_t.
// ----------------------------------------------------------------------------
package eatr_tb_types_pkg;
  import eatr_pkg::*;

  typedef struct {
    ang_t pitch;
    ang_t roll;
    ang_t yaw;
  } angles_t;
endpackage

/* tb/euler_angles_to_rotation_matrix_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Euler angles to rotation matrix: testbench
// Drives angle words through the valid/ready input channel, predicts each
// matrix word with a fixed-point CORDIC model and checks every entry in order.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_test;
  import eatr_pkg::*;
  import eatr_tb_types_pkg::*;

  localparam int LIMIT = 400000;

  class matrix_scoreboard;
    mat_t expected_q[$];
    int   errors;

    // Floor shift and round-half-away shift on 64-bit values.
    function automatic longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function automatic longint rshift(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (s - 1))) >>> s;
      return (v < 0) ? -m : m;
    endfunction

    // The Q2.30 triple terms sum to Q60 and fit a longint.
    function automatic logic signed [MAT_W-1:0] to_q15(longint q60);
      longint v;
      v = rshift(q60, 60 - OUT_FRAC_BITS);
      if (v > 32767) v = 32767;
      if (v < -32767) v = -32767;
      return v[MAT_W-1:0];
    endfunction

    function automatic void sine_cosine(ang_t raw, output longint c, output longint s);
      longint atan_tab[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2, 1, 0};
      longint a, t, x, y, z, dx, dy;
      bit cneg;
      a = longint'(raw) % 92160;
      cneg = 0;
      if (a < 0) a += 92160;
      if (a <= 23040) t = a;
      else if (a < 69120) begin
        t = 46080 - a;
        cneg = 1;
      end else t = a - 92160;
      z = rshift(t * 74961321, 10);
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = fshift(y, i & 31);
        dy = fshift(x, i & 31);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i & 31];
        end else begin
          x += dx; y -= dy; z += atan_tab[i & 31];
        end
      end
      c = cneg ? -x : x;
      s = y;
    endfunction

    function void note_angles(angles_t a);
      longint cp, sp, cr, sr, cy, sy, spsy, spcy;
      mat_t m;
      sine_cosine(a.pitch, cp, sp);
      sine_cosine(a.roll, cr, sr);
      sine_cosine(a.yaw, cy, sy);
      spsy = rshift(sp * sy, 30);
      spcy = rshift(sp * cy, 30);
      m.m00 = to_q15(cr * cy + sr * spsy);
      m.m01 = to_q15(-(cr * sy) + sr * spcy);
      m.m02 = to_q15(sr * cp);
      m.m10 = to_q15(cp * sy);
      m.m11 = to_q15(cp * cy);
      m.m12 = to_q15(-(sp <<< 30));
      m.m20 = to_q15(-(sr * cy) + cr * spsy);
      m.m21 = to_q15(sr * sy + cr * spcy);
      m.m22 = to_q15(cr * cp);
      expected_q.push_back(m);
    endfunction

    function void check_matrix(mat_t got);
      mat_t e;
      if (expected_q.size() == 0) begin
        $error("matrix word with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.m00 !== e.m00) begin $error("m00 exp %0d got %0d", e.m00, got.m00); errors++; end
      if (got.m01 !== e.m01) begin $error("m01 exp %0d got %0d", e.m01, got.m01); errors++; end
      if (got.m02 !== e.m02) begin $error("m02 exp %0d got %0d", e.m02, got.m02); errors++; end
      if (got.m10 !== e.m10) begin $error("m10 exp %0d got %0d", e.m10, got.m10); errors++; end
      if (got.m11 !== e.m11) begin $error("m11 exp %0d got %0d", e.m11, got.m11); errors++; end
      if (got.m12 !== e.m12) begin $error("m12 exp %0d got %0d", e.m12, got.m12); errors++; end
      if (got.m20 !== e.m20) begin $error("m20 exp %0d got %0d", e.m20, got.m20); errors++; end
      if (got.m21 !== e.m21) begin $error("m21 exp %0d got %0d", e.m21, got.m21); errors++; end
      if (got.m22 !== e.m22) begin $error("m22 exp %0d got %0d", e.m22, got.m22); errors++; end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   send_idle_pct = 35;
  int   recv_idle_pct = 47;
  int   cycle_count = 0;

  eatr_in_if  in_ch ();
  eatr_out_if out_ch ();

  matrix_scoreboard board = new();

  euler_angles_to_rotation_matrix dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.pitch_deg = '0;
    in_ch.roll_deg  = '0;
    in_ch.yaw_deg   = '0;
    out_ch.ready    = 1'b0;
  end

  // Receiver: stall at random, check every accepted word.
  always @(posedge clk_i) begin
    mat_t got;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.m00, out_ch.m01, out_ch.m02, out_ch.m10, out_ch.m11,
              out_ch.m12, out_ch.m20, out_ch.m21, out_ch.m22};
      board.check_matrix(got);
    end
    out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Valid stays high after an accepted word; idle cycles and drain() drop it.
  task automatic send_angles(angles_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pitch_deg <= a.pitch;
    in_ch.roll_deg  <= a.roll;
    in_ch.yaw_deg   <= a.yaw;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_angles(a);
  endtask

  function automatic ang_t pick_angle();
    case ($urandom_range(9))
      0:       return ang_t'($urandom);                 // any pattern
      1:       return ang_t'(23040 * (int'($urandom_range(8)) - 4) +
                             (int'($urandom_range(4)) - 2));
      default: return ang_t'(int'($urandom_range(184320)) - 92160);
    endcase
  endfunction

  task automatic random_block(int n);
    angles_t a;
    repeat (n) begin
      a.pitch = pick_angle();
      a.roll  = pick_angle();
      a.yaw   = pick_angle();
      send_angles(a);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    angles_t a;
    ang_t edges[12] = '{0, 23040, -23040, 46080, -46080, 69120, 92160, -92160,
                        18'sh1FFFF, -18'sh20000, 1, -1};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: quarter turns, full turns, out-of-range patterns.
    for (int i = 0; i < 12; i++) begin
      a.pitch = edges[i];
      a.roll  = edges[(i + 5) % 12];
      a.yaw   = edges[(i + 9) % 12];
      send_angles(a);
    end
    a = '{18'sh1FFFF, -18'sh20000, 18'sh15555};
    send_angles(a);
    a = '{-18'sh20000, 18'sh1FFFF, 18'sh2AAAA};
    send_angles(a);

    random_block(280);
    // Hold off until the pipe is empty, then restart.
    drain();
    send_idle_pct = 47;
    recv_idle_pct = 35;
    random_block(280);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_block(280);
    drain();
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycle_count > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
